@@ rtl/core/prt_pkg.sv @@
// shared widths and the scan control type of the peer registry table
`timescale 1ns / 1ps

package prt_pkg;

    localparam int IP_W       = 32;
    localparam int PORT_W     = 16;
    localparam int ENDPOINT_W = IP_W + PORT_W;

    // control that travels with one registered ram read into the lister
    typedef struct packed {
        logic check;   // read data of the last cycle belongs to a listed slot
        logic used;    // that slot holds an endpoint
        logic flush;   // scan is over, give the final word
    } prt_scan_ctl_t;

endpackage

@@ rtl/core/prt_ram.sv @@
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module prt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/prt_lister.sv @@
// compares each scanned slot with the sender and emits peer words, one held back
`timescale 1ns / 1ps

module prt_lister
    import prt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  prt_scan_ctl_t         ctl,
    input  logic [ENDPOINT_W-1:0] rd_data,
    input  logic [IP_W-1:0]       sender_ip,
    input  logic [PORT_W-1:0]     sender_port,
    output logic                  result_strobe,
    output logic [IP_W-1:0]       peer_ip,
    output logic [PORT_W-1:0]     peer_port,
    output logic                  peer_valid,
    output logic                  last_item
);

    logic                  hold_vld_reg, hold_vld_next;
    logic [ENDPOINT_W-1:0] hold_data_reg, hold_data_next;
    logic                  strobe_reg, strobe_next;
    logic                  valid_reg, valid_next;
    logic                  last_reg, last_next;
    logic [ENDPOINT_W-1:0] out_data_reg, out_data_next;
    logic                  hit;

    // slot is listed when it holds an endpoint other than the sender
    assign hit = ctl.check && ctl.used && (rd_data != {sender_ip, sender_port});

    // one word is held back so the final one can carry the last flag
    always_comb
    begin
        hold_vld_next  = hold_vld_reg;
        hold_data_next = hold_data_reg;
        strobe_next    = 1'b0;
        valid_next     = valid_reg;
        last_next      = last_reg;
        out_data_next  = out_data_reg;
        if (hit)
        begin
            hold_vld_next  = 1'b1;
            hold_data_next = rd_data;
            if (hold_vld_reg)
            begin
                strobe_next   = 1'b1;
                valid_next    = 1'b1;
                last_next     = 1'b0;
                out_data_next = hold_data_reg;
            end
        end
        else if (ctl.flush)
        begin
            hold_vld_next = 1'b0;
            strobe_next   = 1'b1;
            last_next     = 1'b1;
            valid_next    = hold_vld_reg;
            out_data_next = hold_vld_reg ? hold_data_reg : '0;
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            hold_vld_reg <= hold_vld_next;
            strobe_reg   <= strobe_next;
        end
    end

    // payload flops
    always_ff @(posedge clk)
    begin
        hold_data_reg <= hold_data_next;
        valid_reg     <= valid_next;
        last_reg      <= last_next;
        out_data_reg  <= out_data_next;
    end

    assign result_strobe = strobe_reg;
    assign peer_ip       = out_data_reg[ENDPOINT_W-1:PORT_W];
    assign peer_port     = out_data_reg[PORT_W-1:0];
    assign peer_valid    = valid_reg;
    assign last_item     = last_reg;

endmodule

@@ rtl/core/peer_registry_table.sv @@
// peer registry table top level: sequencer, slot ram and peer lister
//
// channel   direction  handshake                 word
// command   in         start && !busy            client_ip, client_port
// result    out        result_strobe (no stall)  peer_ip, peer_port, peer_valid, last_item
//
// during a heartbeat busy stays high through one ram write of the
// sender, one ram read per slot, a drain step and a final step
// a full table first copies the upper half down to the lower half
// through the single ram read and write port
// results show one per cycle while the scan finds peers; the final word leaves
// in the cycle busy drops, and the receiver cannot stall them
// reset empties the table at once through the fill count, the ram is not swept
`timescale 1ns / 1ps

module peer_registry_table
    import prt_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [IP_W-1:0]   client_ip,
    input  logic [PORT_W-1:0] client_port,
    output logic              result_strobe,
    output logic [IP_W-1:0]   peer_ip,
    output logic [PORT_W-1:0] peer_port,
    output logic              peer_valid,
    output logic              last_item
);

    localparam int AW   = $clog2(SLOT_COUNT);
    localparam int CW   = $clog2(SLOT_COUNT + 1);
    localparam int HALF = SLOT_COUNT / 2;
    localparam bit ODD  = (SLOT_COUNT % 2) != 0;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHIFT = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_LIST  = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         fill_reg, fill_next;
    logic                  top_used_reg, top_used_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_addr_reg, pend_addr_next;
    logic [IP_W-1:0]       ip_reg, ip_next;
    logic [PORT_W-1:0]     port_reg, port_next;
    prt_scan_ctl_t         ctl_reg, ctl_next;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ENDPOINT_W-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [ENDPOINT_W-1:0] rd_data;
    logic                  slot_used;

    // a slot holds an endpoint if it is below the fill count, or it is the
    // top slot that a move on an odd table left in place
    assign slot_used = (cnt_reg < fill_reg)
                    || ((cnt_reg == CW'(SLOT_COUNT - 1)) && top_used_reg);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        fill_next      = fill_reg;
        top_used_next  = top_used_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        ip_next        = ip_reg;
        port_next      = port_reg;
        ctl_next       = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = pend_reg;
        wr_addr        = pend_addr_reg;
        wr_data        = rd_data;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ip_next   = client_ip;
                    port_next = client_port;
                    cnt_next  = '0;
                    state_next = (fill_reg == CW'(SLOT_COUNT)) ? ST_SHIFT : ST_WRITE;
                end
            end
            ST_SHIFT:
            begin
                // copy slot cnt+HALF down to slot cnt, the write trails the read through the pend register
                if (cnt_reg < CW'(HALF))
                begin
                    rd_en          = 1'b1;
                    rd_addr        = AW'(cnt_reg) + AW'(HALF);
                    pend_next      = 1'b1;
                    pend_addr_next = AW'(cnt_reg);
                    cnt_next       = cnt_reg + 1'b1;
                end
                else
                begin
                    fill_next     = CW'(HALF);
                    top_used_next = ODD ? top_used_reg : 1'b0;
                    state_next    = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                // store the sender in the lowest empty slot
                wr_en   = 1'b1;
                wr_addr = fill_reg[AW-1:0];
                wr_data = {ip_reg, port_reg};
                if (fill_reg == CW'(SLOT_COUNT - 1))
                begin
                    top_used_next = 1'b1;
                end
                if ((fill_reg + 1'b1 == CW'(SLOT_COUNT - 1)) && top_used_reg)
                begin
                    fill_next = CW'(SLOT_COUNT);
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                end
                cnt_next   = '0;
                state_next = ST_LIST;
            end
            ST_LIST:
            begin
                // one slot read per cycle, checked by the lister in the next cycle
                if (cnt_reg < CW'(SLOT_COUNT))
                begin
                    rd_en          = 1'b1;
                    rd_addr        = cnt_reg[AW-1:0];
                    ctl_next.check = 1'b1;
                    ctl_next.used  = slot_used;
                    cnt_next       = cnt_reg + 1'b1;
                end
                else
                begin
                    ctl_next.flush = 1'b1;
                    state_next     = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            fill_reg     <= '0;
            top_used_reg <= 1'b0;
            pend_reg     <= 1'b0;
            ctl_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            fill_reg     <= fill_next;
            top_used_reg <= top_used_next;
            pend_reg     <= pend_next;
            ctl_reg      <= ctl_next;
        end
    end

    // payload flops
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        ip_reg        <= ip_next;
        port_reg      <= port_next;
    end

    assign busy = (state_reg != ST_IDLE);

    // slot endpoint store
    prt_ram #(
        .WIDTH (ENDPOINT_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // compare against the sender and drive the result word
    prt_lister u_lister (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl_reg),
        .rd_data       (rd_data),
        .sender_ip     (ip_reg),
        .sender_port   (port_reg),
        .result_strobe (result_strobe),
        .peer_ip       (peer_ip),
        .peer_port     (peer_port),
        .peer_valid    (peer_valid),
        .last_item     (last_item)
    );

    // fill count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(SLOT_COUNT))
        else $error("fill count beyond table size");

    // a heartbeat on a full table moves the upper half first
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && fill_reg == CW'(SLOT_COUNT)) |=> (state_reg == ST_SHIFT))
        else $error("full table not moved before insert");

    // the final cycle is always followed by the flagged last word
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |=> (result_strobe && last_item))
        else $error("missing last word after scan");

    // an empty word only ever closes a heartbeat
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !peer_valid) |-> last_item)
        else $error("empty word not flagged last");

endmodule
